@@ rtl/madt_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// MADT parser package
// Shared types, table layout constants and entry type codes for the MADT
// entry parser.
// ----------------------------------------------------------------------------
package madt_pkg;

  // Table layout
  localparam int HDR_LEN     = 44;
  localparam int LAPIC_POS   = 36;
  localparam int ENTRY_KEEP  = 12;
  localparam int ENTRY_AW    = $clog2(ENTRY_KEEP);

  // Core list
  localparam int CORE_SLOTS  = 64;
  localparam int CORE_AW     = $clog2(CORE_SLOTS);
  localparam int CNT_W       = $clog2(CORE_SLOTS + 1);

  // Entry type codes
  localparam logic [7:0] KIND_LAPIC     = 8'd0;
  localparam logic [7:0] KIND_IOAPIC    = 8'd1;
  localparam logic [7:0] KIND_LAPIC_OVR = 8'd5;

  // Minimum entry lengths
  localparam logic [7:0] MIN_ENTRY_LEN = 8'd2;
  localparam logic [7:0] MIN_LEN_LAPIC = 8'd8;
  localparam logic [7:0] MIN_LEN_ADDR  = 8'd12;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } byte_item_t;

  typedef struct packed {
    logic        table_ok;
    logic [6:0]  core_total;
    logic [63:0] local_apic_address;
    logic [31:0] io_apic_base;
    logic [5:0]  core_pos;
    logic [7:0]  core_apic_id;
    logic        last_result;
  } result_item_t;

  // Summary handed from the parser to the result sequencer on the final byte.
  typedef struct packed {
    logic             start;
    logic             table_ok;
    logic [6:0]       core_total;
    logic [63:0]      lapic_base;
    logic [31:0]      ioapic_base;
    logic [CNT_W-1:0] stored_cores;
  } summary_t;

  // Write port of the core id store.
  typedef struct packed {
    logic               we;
    logic [CORE_AW-1:0] addr;
    logic [7:0]         data;
  } store_wr_t;

endpackage
`default_nettype wire

@@ rtl/madt_core_store.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// MADT core id store
// Holds the APIC ids of the cores found, one write and one registered read
// port.
// ----------------------------------------------------------------------------
module madt_core_store (
  input  wire logic                        clk,
  input  wire madt_pkg::store_wr_t         wr,
  input  wire logic                        rd_en,
  input  wire logic [madt_pkg::CORE_AW-1:0] rd_addr,
  output logic [7:0]                       rd_data
);
  import madt_pkg::*;

  logic [7:0] mem [CORE_SLOTS];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

@@ rtl/madt_parser.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// MADT byte parser
// Walks the header and variable-length entries one byte per accepted cycle
// and hands a summary to the result sequencer on the final byte.
// ----------------------------------------------------------------------------
module madt_parser (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 accept,
  input  wire madt_pkg::byte_item_t item,
  output madt_pkg::store_wr_t       wr,
  output madt_pkg::summary_t        summ
);
  import madt_pkg::*;

  logic [5:0]       hdr_seen, hdr_seen_next;
  logic [7:0]       ent_off, ent_off_next;
  logic [7:0]       ent_len, ent_len_next;
  logic [7:0]       ent_kind, ent_kind_next;
  logic             stopped, stopped_next;
  logic [63:0]      lapic, lapic_next;
  logic [31:0]      ioapic, ioapic_next;
  logic [CNT_W-1:0] cores, cores_next;
  logic [7:0]       ent_bytes [ENTRY_KEEP];
  logic [7:0]       ent_view [ENTRY_KEEP];
  logic             in_entries;

  logic [7:0] b;
  assign b = item.data_byte;
  assign in_entries = (hdr_seen >= 6'(HDR_LEN)) && !stopped;

  always_comb begin
    logic [7:0] len_eff;
    logic       hdr_ok;
    // Entry bytes as they stand once the current byte is written.
    for (int i = 0; i < ENTRY_KEEP; i++) begin
      ent_view[i] = (ent_off == 8'(i)) ? b : ent_bytes[i];
    end
    hdr_seen_next = hdr_seen;
    ent_off_next  = ent_off;
    ent_len_next  = ent_len;
    ent_kind_next = ent_kind;
    stopped_next  = stopped;
    lapic_next    = lapic;
    ioapic_next   = ioapic;
    cores_next    = cores;
    wr.we         = 1'b0;
    wr.addr       = cores[CORE_AW-1:0];
    wr.data       = ent_view[3];
    len_eff       = (ent_off == 8'd1) ? b : ent_len;

    if (hdr_seen < 6'(HDR_LEN)) begin
      if (hdr_seen >= 6'(LAPIC_POS) && hdr_seen < 6'(LAPIC_POS + 4)) begin
        lapic_next[{hdr_seen[1:0], 3'b000} +: 8] = b;
      end
      hdr_seen_next = hdr_seen + 6'd1;
    end else if (!stopped) begin
      if (ent_off == 8'd0) begin
        ent_kind_next = b;
        ent_off_next  = 8'd1;
      end else if (ent_off == 8'd1 && b < MIN_ENTRY_LEN) begin
        ent_len_next = b;
        stopped_next = 1'b1;
      end else begin
        ent_len_next = len_eff;
        if ({1'b0, ent_off} + 9'd1 == {1'b0, len_eff}) begin
          ent_off_next = 8'd0;
          case (ent_kind)
            KIND_LAPIC: begin
              if (len_eff >= MIN_LEN_LAPIC && (ent_view[4][1:0] != 2'b00) &&
                  cores < CNT_W'(CORE_SLOTS)) begin
                wr.we      = 1'b1;
                cores_next = cores + CNT_W'(1);
              end
            end
            KIND_IOAPIC: begin
              if (len_eff >= MIN_LEN_ADDR && ioapic == 32'd0) begin
                ioapic_next = {ent_view[7], ent_view[6], ent_view[5], ent_view[4]};
              end
            end
            KIND_LAPIC_OVR: begin
              if (len_eff >= MIN_LEN_ADDR) begin
                lapic_next = {ent_view[11], ent_view[10], ent_view[9], ent_view[8],
                              ent_view[7], ent_view[6], ent_view[5], ent_view[4]};
              end
            end
            default: begin
            end
          endcase
        end else begin
          ent_off_next = ent_off + 8'd1;
        end
      end
    end

    wr.we = wr.we && accept;

    hdr_ok            = hdr_seen_next >= 6'(HDR_LEN);
    summ.start        = accept && item.last_byte;
    summ.table_ok     = hdr_ok && (cores_next != '0);
    summ.core_total   = hdr_ok ? 7'(cores_next) : 7'd0;
    summ.lapic_base   = hdr_ok ? lapic_next : 64'd0;
    summ.ioapic_base  = hdr_ok ? ioapic_next : 32'd0;
    summ.stored_cores = cores_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hdr_seen <= '0;
      ent_off  <= '0;
      ent_len  <= '0;
      ent_kind <= '0;
      stopped  <= 1'b0;
      lapic    <= '0;
      ioapic   <= '0;
      cores    <= '0;
    end else if (accept) begin
      if (item.last_byte) begin
        // The run is over: start the next table from a clean state.
        hdr_seen <= '0;
        ent_off  <= '0;
        ent_len  <= '0;
        ent_kind <= '0;
        stopped  <= 1'b0;
        lapic    <= '0;
        ioapic   <= '0;
        cores    <= '0;
      end else begin
        hdr_seen <= hdr_seen_next;
        ent_off  <= ent_off_next;
        ent_len  <= ent_len_next;
        ent_kind <= ent_kind_next;
        stopped  <= stopped_next;
        lapic    <= lapic_next;
        ioapic   <= ioapic_next;
        cores    <= cores_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_entries && ent_off < 8'(ENTRY_KEEP)) begin
      ent_bytes[ent_off[ENTRY_AW-1:0]] <= b;
    end
  end

endmodule
`default_nettype wire

@@ rtl/madt_emitter.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// MADT result sequencer
// Delivers one result item per stored core, or one item when there are none,
// through a store read stage and an output register.
// ----------------------------------------------------------------------------
module madt_emitter (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire madt_pkg::summary_t            summ,
  output logic                               busy,
  output logic                               rd_en,
  output logic [madt_pkg::CORE_AW-1:0]       rd_addr,
  input  wire logic [7:0]                    rd_data,
  output logic                               result_valid,
  input  wire logic                          result_ready,
  output madt_pkg::result_item_t             result_item
);
  import madt_pkg::*;

  logic [CNT_W-1:0] k;
  logic [CNT_W-1:0] n_total;
  logic [CNT_W-1:0] cores;
  logic             snap_ok;
  logic [6:0]       snap_total;
  logic [63:0]      snap_lapic;
  logic [31:0]      snap_ioapic;

  logic             s1_valid;
  logic             s1_have;
  result_item_t     s1_item;
  result_item_t     s1_out;

  logic issue;
  logic s1_move;
  logic have;
  logic last_k;

  assign s1_move = s1_valid && (!result_valid || result_ready);
  assign issue   = busy && (!s1_valid || s1_move);
  assign have    = k < cores;
  assign last_k  = (k + CNT_W'(1)) == n_total;
  assign rd_en   = issue;
  assign rd_addr = k[CORE_AW-1:0];

  // The store data arrives in the cycle after the read, alongside the stage.
  always_comb begin
    s1_out              = s1_item;
    s1_out.core_apic_id = s1_have ? rd_data : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      k            <= '0;
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (summ.start) begin
        busy <= 1'b1;
        k    <= '0;
      end else if (issue) begin
        k <= k + CNT_W'(1);
        if (last_k) begin
          busy <= 1'b0;
        end
      end
      if (issue) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (summ.start) begin
      n_total     <= (summ.stored_cores == '0) ? CNT_W'(1) : summ.stored_cores;
      cores       <= summ.stored_cores;
      snap_ok     <= summ.table_ok;
      snap_total  <= summ.core_total;
      snap_lapic  <= summ.lapic_base;
      snap_ioapic <= summ.ioapic_base;
    end
    if (issue) begin
      s1_have <= have;
      s1_item <= '{table_ok:           snap_ok,
                   core_total:         snap_total,
                   local_apic_address: snap_lapic,
                   io_apic_base:       snap_ioapic,
                   core_pos:           have ? 6'(k) : 6'd0,
                   core_apic_id:       8'd0,
                   last_result:        last_k};
    end
    if (s1_move) begin
      result_item <= s1_out;
    end
  end

  // A new run only starts once the previous one has issued all its reads.
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    summ.start |-> !busy)
    else $error("run started while results were still being issued");

  a_k_in_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (k < n_total))
    else $error("result counter ran past the result count");

  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    (issue && last_k) |=> !busy)
    else $error("sequencer stayed busy after the final result was issued");

  a_s1_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_move) |=> (s1_valid && $stable(s1_item)))
    else $error("read stage lost or changed a stalled result");

endmodule
`default_nettype wire

@@ rtl/madt_entry_parser_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// MADT entry parser
// Parses an ACPI MADT byte stream and reports the cores and APIC addresses.
// ----------------------------------------------------------------------------
// Table bytes are taken one item per cycle while input is not held off. The
// final byte of a table starts a run of results, one per stored core (at most
// 64) or a single one when no core was found, delivered at one item per cycle
// while the output is taken; the first result passes the store read stage and
// the output register. From the final byte until the read of the last result
// has been issued to the core id store, byte input is held off, so the input
// stalls while the max(C,1) result reads of a table of C cores are issued.
module madt_entry_parser_unit (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   byte_valid,
  output logic                        byte_ready,
  input  wire madt_pkg::byte_item_t   byte_item,
  output logic                        result_valid,
  input  wire logic                   result_ready,
  output madt_pkg::result_item_t      result_item
);
  import madt_pkg::*;

  logic               accept;
  logic               busy;
  store_wr_t          wr;
  summary_t           summ;
  logic               rd_en;
  logic [CORE_AW-1:0] rd_addr;
  logic [7:0]         rd_data;

  assign byte_ready = !busy;
  assign accept     = byte_valid && byte_ready;

  madt_parser u_parser (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (byte_item),
    .wr     (wr),
    .summ   (summ)
  );

  madt_core_store u_store (
    .clk     (clk),
    .wr      (wr),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  madt_emitter u_emitter (
    .clk          (clk),
    .rst          (rst),
    .summ         (summ),
    .busy         (busy),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_item  (result_item)
  );

endmodule
`default_nettype wire
